// ===== src/nfsa_pkg.sv =====
// Package for the next-fit slot allocator.
// Holds the request and result types, status and request codes, and the bitmap helpers.
// No dependencies.
`default_nettype none

package nfsa_pkg;

    localparam int SLOTS       = 1024;
    localparam int WORD_BITS   = 32;
    localparam int WORDS       = SLOTS / WORD_BITS;
    localparam int IDX_W       = 10;
    localparam int CNT_W       = 11;
    localparam int WIDX_W      = $clog2(WORDS);
    localparam int BIDX_W      = $clog2(WORD_BITS);
    localparam int NW_W        = CNT_W - BIDX_W;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;
    localparam logic [1:0] ST_ALREADY = 2'd3;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic [IDX_W-1:0] slot_index;
    } nfsa_req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] granted_index;
        logic [CNT_W-1:0] free_count;
        logic             pool_full;
        logic             pool_empty;
    } nfsa_rsp_t;

    typedef struct packed {
        logic accept;
        logic chk;
        logic srch;
        logic load_rsp;
    } nfsa_cmd_t;

    typedef struct packed {
        logic need_search;
        logic rsp_free;
    } nfsa_sts_t;

    function automatic logic [CNT_W-1:0] eff_size(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = CNT_W'(1);
        end
        else if (v > CNT_W'(SLOTS))
        begin
            r = CNT_W'(SLOTS);
        end
        return r;
    endfunction

    function automatic logic [BIDX_W-1:0] ffs_word(input logic [WORD_BITS-1:0] v);
        logic [BIDX_W-1:0] r;
        r = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = BIDX_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [WIDX_W-1:0] ffs_summary(input logic [WORDS-1:0] v);
        logic [WIDX_W-1:0] r;
        r = '0;
        for (int i = WORDS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = WIDX_W'(i);
            end
        end
        return r;
    endfunction

    // bits of word w that lie below the active size n
    function automatic logic [WORD_BITS-1:0] act_mask(input logic [WIDX_W-1:0] w,
                                                      input logic [CNT_W-1:0]  n);
        logic [NW_W-1:0]      nw;
        logic [BIDX_W-1:0]    nr;
        logic [WORD_BITS-1:0] m;
        nw = n[CNT_W-1:BIDX_W];
        nr = n[BIDX_W-1:0];
        if (NW_W'(w) < nw)
        begin
            m = '1;
        end
        else if (NW_W'(w) == nw)
        begin
            m = (WORD_BITS'(1) << nr) - WORD_BITS'(1);
        end
        else
        begin
            m = '0;
        end
        return m;
    endfunction

    function automatic logic [WORDS-1:0] summary_init(input logic [CNT_W-1:0] n);
        logic [WORDS-1:0] s;
        s = '0;
        for (int i = 0; i < WORDS; i++)
        begin
            s[i] = |act_mask(WIDX_W'(i), n);
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== src/nfsa_ctrl.sv =====
// Controller for the next-fit slot allocator: request sequencing state machine.
// Depends on nfsa_pkg for the command and status structs.
`default_nettype none

module nfsa_ctrl
    import nfsa_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_stall,
    input  wire nfsa_sts_t sts,
    output nfsa_cmd_t      cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CHK  = 2'd1;
    localparam logic [1:0] S_SRCH = 2'd2;
    localparam logic [1:0] S_RESP = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                cmd.chk    = 1'b1;
                state_next = sts.need_search ? S_SRCH : S_RESP;
            end
            S_SRCH:
            begin
                cmd.srch   = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (sts.rsp_free)
                begin
                    cmd.load_rsp = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/nfsa_dpath.sv =====
// Datapath for the next-fit slot allocator: free bitmap, summary vector, counters, result register.
// Depends on nfsa_pkg; driven by commands from nfsa_ctrl.
`default_nettype none

module nfsa_dpath
    import nfsa_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire nfsa_req_t        req,
    input  wire logic             rsp_stall,
    output logic                  rsp_valid,
    output nfsa_rsp_t             rsp,
    input  wire logic             cfg_wr_en,
    input  wire logic [CNT_W-1:0] cfg_wr_data,
    input  wire nfsa_cmd_t        cmd,
    output nfsa_sts_t             sts
);

    logic [WORD_BITS-1:0] mem [WORDS];
    logic [WORD_BITS-1:0] mem_q_reg;
    logic                 rv_q_reg;
    logic [WORDS-1:0]     row_valid_reg;
    logic [WORDS-1:0]     row_valid_next;

    logic [CNT_W-1:0]     n_reg;
    logic [CNT_W-1:0]     n_next;
    logic [CNT_W-1:0]     total_reg;
    logic [CNT_W-1:0]     total_next;
    logic [IDX_W-1:0]     cursor_reg;
    logic [IDX_W-1:0]     cursor_next;
    logic [WORDS-1:0]     summary_reg;
    logic [WORDS-1:0]     summary_next;
    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;

    nfsa_req_t            op_reg;
    logic [IDX_W-1:0]     start_reg;
    logic [WIDX_W-1:0]    word2_reg;
    logic [1:0]           res_status_reg;
    logic [IDX_W-1:0]     res_grant_reg;
    nfsa_rsp_t            rsp_reg;

    logic [IDX_W-1:0]     start_calc;
    logic [CNT_W-1:0]     cursor_inc;
    logic [CNT_W-1:0]     cfg_eff;

    logic                 rd_en;
    logic [WIDX_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [WIDX_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    logic [WORD_BITS-1:0] rword;
    logic [WIDX_W-1:0]    ws;
    logic [BIDX_W-1:0]    bs;
    logic [WORD_BITS-1:0] m1;
    logic                 hit1;
    logic [BIDX_W-1:0]    b1;
    logic [WORD_BITS-1:0] hi;
    logic [WIDX_W-1:0]    w2;
    logic [WORD_BITS-1:0] m2;
    logic [BIDX_W-1:0]    b2;
    logic [WIDX_W-1:0]    fw;
    logic [BIDX_W-1:0]    fb;
    logic                 out_of_range;

    assign cursor_inc = {1'b0, cursor_reg} + CNT_W'(1);
    assign start_calc = (cursor_inc == n_reg) ? '0 : cursor_inc[IDX_W-1:0];
    assign cfg_eff    = eff_size(cfg_wr_data);

    assign rword = rv_q_reg ? mem_q_reg : '1;

    assign ws   = start_reg[IDX_W-1:BIDX_W];
    assign bs   = start_reg[BIDX_W-1:0];
    assign m1   = rword & ({WORD_BITS{1'b1}} << bs) & act_mask(ws, n_reg);
    assign hit1 = |m1;
    assign b1   = ffs_word(m1);

    assign hi = (({WORD_BITS{1'b1}} << ws) << 1) & summary_reg;
    assign w2 = (hi != '0) ? ffs_summary(hi) : ffs_summary(summary_reg);

    assign m2 = rword & act_mask(word2_reg, n_reg);
    assign b2 = ffs_word(m2);

    assign fw           = op_reg.slot_index[IDX_W-1:BIDX_W];
    assign fb           = op_reg.slot_index[BIDX_W-1:0];
    assign out_of_range = {1'b0, op_reg.slot_index} >= n_reg;

    assign sts.need_search = (op_reg.req_type == REQ_ALLOC) && (total_reg != '0) && !hit1;
    assign sts.rsp_free    = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = rword;
        n_next         = n_reg;
        total_next     = total_reg;
        cursor_next    = cursor_reg;
        summary_next   = summary_reg;
        row_valid_next = row_valid_reg;
        rsp_valid_next = rsp_valid_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        if (cmd.load_rsp)
        begin
            rsp_valid_next = 1'b1;
        end

        if (cmd.accept)
        begin
            rd_en   = 1'b1;
            rd_addr = (req.req_type == REQ_ALLOC) ? start_calc[IDX_W-1:BIDX_W]
                                                  : req.slot_index[IDX_W-1:BIDX_W];
        end

        if (cmd.chk)
        begin
            if (op_reg.req_type == REQ_ALLOC)
            begin
                if (total_reg != '0)
                begin
                    if (hit1)
                    begin
                        wr_en            = 1'b1;
                        wr_addr          = ws;
                        wr_data          = rword & ~(WORD_BITS'(1) << b1);
                        summary_next[ws] = |(wr_data & act_mask(ws, n_reg));
                        total_next       = total_reg - CNT_W'(1);
                        cursor_next      = {ws, b1};
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = w2;
                    end
                end
            end
            else if (!out_of_range && !rword[fb])
            begin
                wr_en            = 1'b1;
                wr_addr          = fw;
                wr_data          = rword | (WORD_BITS'(1) << fb);
                summary_next[fw] = 1'b1;
                total_next       = total_reg + CNT_W'(1);
            end
        end

        if (cmd.srch)
        begin
            wr_en                   = 1'b1;
            wr_addr                 = word2_reg;
            wr_data                 = rword & ~(WORD_BITS'(1) << b2);
            summary_next[word2_reg] = |(wr_data & act_mask(word2_reg, n_reg));
            total_next              = total_reg - CNT_W'(1);
            cursor_next             = {word2_reg, b2};
        end

        if (wr_en)
        begin
            row_valid_next[wr_addr] = 1'b1;
        end

        // reinitialise the pool
        if (cfg_wr_en)
        begin
            n_next         = cfg_eff;
            total_next     = cfg_eff;
            cursor_next    = '0;
            summary_next   = summary_init(cfg_eff);
            row_valid_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg <= mem[rd_addr];
            rv_q_reg  <= row_valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg         <= CNT_W'(SLOTS);
            total_reg     <= CNT_W'(SLOTS);
            cursor_reg    <= '0;
            summary_reg   <= summary_init(CNT_W'(SLOTS));
            row_valid_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            n_reg         <= n_next;
            total_reg     <= total_next;
            cursor_reg    <= cursor_next;
            summary_reg   <= summary_next;
            row_valid_reg <= row_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg    <= req;
            start_reg <= start_calc;
        end
        if (cmd.chk)
        begin
            word2_reg     <= w2;
            res_grant_reg <= '0;
            if (op_reg.req_type == REQ_ALLOC)
            begin
                if (total_reg == '0)
                begin
                    res_status_reg <= ST_FULL;
                end
                else
                begin
                    res_status_reg <= ST_OK;
                    res_grant_reg  <= hit1 ? {ws, b1} : '0;
                end
            end
            else if (out_of_range)
            begin
                res_status_reg <= ST_RANGE;
            end
            else if (rword[fb])
            begin
                res_status_reg <= ST_ALREADY;
            end
            else
            begin
                res_status_reg <= ST_OK;
            end
        end
        if (cmd.srch)
        begin
            res_grant_reg <= {word2_reg, b2};
        end
        if (cmd.load_rsp)
        begin
            rsp_reg.status        <= res_status_reg;
            rsp_reg.granted_index <= res_grant_reg;
            rsp_reg.free_count    <= total_reg;
            rsp_reg.pool_full     <= (total_reg == '0);
            rsp_reg.pool_empty    <= (total_reg == n_reg);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// ===== src/next_fit_slot_allocator_unit.sv =====
// Top level of the next-fit slot allocator: joins the controller and the datapath.
// Depends on nfsa_pkg, nfsa_ctrl and nfsa_dpath.
//
//   channel   direction   handshake              payload
//   request   in          req_valid / req_stall  req  (nfsa_req_t)
//   result    out         rsp_valid / rsp_stall  rsp  (nfsa_rsp_t)
//   config    in          cfg_wr_en              cfg_wr_data (active_slots)
//
// One request at a time: a free, or an allocate that finds a slot in the word at the
// cursor, passes through the accept, check and response states; a search state is added
// when the summary vector picks another word. The bitmap memory is single-port with
// registered read.
// A result waits in the output register while rsp_stall is high; the next request is
// taken, and holds before its result only if the previous one is still unclaimed.
// Reset and configuration writes free every slot at once through per-row valid flags;
// no clearing pass.
`default_nettype none

module next_fit_slot_allocator_unit
    import nfsa_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_stall,
    input  wire nfsa_req_t        req,
    output logic                  rsp_valid,
    input  wire logic             rsp_stall,
    output nfsa_rsp_t             rsp,
    input  wire logic             cfg_wr_en,
    input  wire logic [CNT_W-1:0] cfg_wr_data
);

    nfsa_cmd_t cmd;
    nfsa_sts_t sts;

    nfsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    nfsa_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp_stall   (rsp_stall),
        .rsp_valid   (rsp_valid),
        .rsp         (rsp),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

`default_nettype wire
